>>> hw/rtl/glyph_bitblit_1bpp_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the glyph blitter
// Shared property shapes used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GLYPH_BITBLIT_1BPP_MACROS_SVH
`define GLYPH_BITBLIT_1BPP_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define GBB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define GBB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checks what the cycle after a reset cycle shows.
`define GBB_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gbb_pkg.sv
// ---------------------------------------------------------------------------
// gbb_pkg
// Types and constants shared by the glyph blitter and its checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbb_pkg;

   localparam int GBB_SCREEN_WIDTH  = 128;
   localparam int GBB_SCREEN_HEIGHT = 64;
   localparam int GBB_GLYPH_COUNT   = 144;
   localparam int GBB_GLYPH_W       = 5;
   localparam int GBB_GLYPH_H       = 7;

   // Glyph pattern as stored, and the same pattern padded with zeros to 64 bits.
   localparam int PAT_BITS  = 35;
   localparam int PAT_EXT_W = 64;

   localparam int KIND_W      = 3;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 3'd0,
      KIND_TEXT  = 3'd1,
      KIND_PIXEL = 3'd2,
      KIND_READ  = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ORIGIN,
      ST_BLIT,
      ST_DRAIN,
      ST_READ,
      ST_CLEAR,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/glyph_bitblit_1bpp.sv
// ---------------------------------------------------------------------------
// glyph_bitblit_1bpp
// Character generator with a 1-bit-per-pixel frame store and a glyph store.
// ---------------------------------------------------------------------------
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | tuser kind, tdata item fields
// rsp     | out       | rsp_tvalid/rsp_tready | tdata read_data
//
// One request is in work at a time. A draw passes from acceptance through
// ORIGIN, BLIT and DRAIN to DONE, where the response is loaded before the
// next acceptance: the frame store has one read and one write port and every
// glyph row costs two byte read-modify-writes. Load and unknown kinds go
// straight to DONE and a read through READ; a clear sweeps the frame store
// one byte a cycle. After reset the same sweep runs before req_tready
// rises. A stalled response does not block the next request from entering.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_bitblit_1bpp
   import gbb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = GBB_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = GBB_SCREEN_HEIGHT,
   parameter int GLYPH_COUNT   = GBB_GLYPH_COUNT,
   parameter int GLYPH_W       = GBB_GLYPH_W,
   parameter int GLYPH_H       = GBB_GLYPH_H
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // char_code[7:0], glyph_bits[42:8], text_col[50:43], text_row[58:51],
   // pixel_x[66:59], pixel_y[74:67], byte_address[84:75], zero[87:85]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind[2:0]
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[7:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int FRAME_BYTES = SCREEN_WIDTH * SCREEN_HEIGHT / 8;
   localparam int PIX_AW      = $clog2(FRAME_BYTES);
   localparam int GIX_W       = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
   localparam int LIN_W       = $clog2((255 + GLYPH_H) * SCREEN_WIDTH + 255 + GLYPH_W + 1);
   localparam int BIX_W       = LIN_W - 2;
   localparam int OPC_W       = $clog2(2 * GLYPH_H);

   localparam logic [OPC_W-1:0]  OP_LAST      = OPC_W'(2 * GLYPH_H - 1);
   localparam logic [PIX_AW-1:0] CLR_LAST     = PIX_AW'(FRAME_BYTES - 1);
   localparam logic [BIX_W-1:0]  FRAME_BYTES_B = BIX_W'(FRAME_BYTES);
   localparam logic [8:0]        GLYPH_COUNT_B = 9'(GLYPH_COUNT);
   localparam logic [LIN_W-1:0]  ROW_STEP     = LIN_W'(SCREEN_WIDTH);
   localparam logic [7:0]        TEXT_DX      = 8'(GLYPH_W + 1);
   localparam logic [7:0]        TEXT_DY      = 8'(GLYPH_H + 1);
   localparam logic [7:0]        ROW_MASK     = 8'(8'hFF << (8 - GLYPH_W));

   // Request fields.
   logic [KIND_W-1:0]   req_kind;
   logic [7:0]          req_char_code;
   logic [PAT_BITS-1:0] req_glyph_bits;
   logic [7:0]          req_text_col;
   logic [7:0]          req_text_row;
   logic [7:0]          req_pixel_x;
   logic [7:0]          req_pixel_y;
   logic [9:0]          req_byte_address;

   assign req_kind         = req_tuser;
   assign req_char_code    = req_tdata[7:0];
   assign req_glyph_bits   = req_tdata[42:8];
   assign req_text_col     = req_tdata[50:43];
   assign req_text_row     = req_tdata[58:51];
   assign req_pixel_x      = req_tdata[66:59];
   assign req_pixel_y      = req_tdata[74:67];
   assign req_byte_address = req_tdata[84:75];

   state_type state_ff, state_in;

   logic [PAT_BITS-1:0]    glyph_mem_ff [GLYPH_COUNT];
   logic [PAT_BITS-1:0]    glyph_rd_ff;
   logic [GLYPH_COUNT-1:0] gvalid_ff, gvalid_in;
   logic                   glyph_we;
   logic [GIX_W-1:0]       glyph_idx;
   logic                   code_ok;

   logic [7:0]        pix_mem_ff [FRAME_BYTES];
   logic [7:0]        pix_rd_ff;
   logic              pix_we;
   logic [PIX_AW-1:0] pix_wa, pix_ra;
   logic [7:0]        pix_wd, pix_rd;
   logic              byp_ff, byp_in;
   logic [7:0]        byp_data_ff;

   logic [7:0]           x0_ff, x0_in, y0_ff, y0_in, col_m1, row_m1;
   logic                 glyph_ok_ff, glyph_ok_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [LIN_W-1:0]     lin_ff, lin_in;
   logic [PAT_EXT_W-1:0] pat_sr_ff, pat_sr_in;
   logic [OPC_W-1:0]     op_cnt_ff, op_cnt_in;
   logic [PIX_AW-1:0]    clr_cnt_ff, clr_cnt_in;

   // Write stage of the byte read-modify-write pipeline.
   logic              wr_pend_ff, wr_pend_in;
   logic [PIX_AW-1:0] wr_idx_ff, wr_idx_in;
   logic [7:0]        wr_mask_ff, wr_mask_in, wr_bits_ff, wr_bits_in;

   logic [7:0]  res_ff, res_in;
   logic        rsp_load;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]  rsp_data_ff;

   // Byte operation of the current blit cycle.
   logic [7:0]       row8;
   logic [15:0]      win16, msk16;
   logic             op_hi;
   logic [BIX_W-1:0] op_idx;
   logic             accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign code_ok   = {1'b0, req_char_code} < GLYPH_COUNT_B;
   assign glyph_idx = req_char_code[GIX_W-1:0];
   assign glyph_we  = accept && (req_kind == KIND_LOAD) && code_ok;

   assign col_m1 = req_text_col - 8'd1;
   assign row_m1 = req_text_row - 8'd1;

   assign row8   = pat_sr_ff[PAT_EXT_W-1 -: 8] & ROW_MASK;
   assign win16  = {row8, 8'h00} >> lin_ff[2:0];
   assign msk16  = {ROW_MASK, 8'h00} >> lin_ff[2:0];
   assign op_hi  = op_cnt_ff[0];
   assign op_idx = BIX_W'(lin_ff >> 3) + BIX_W'(op_hi);

   // A read issued in the cycle that wrote the same byte sees the new value.
   assign pix_rd = byp_ff ? byp_data_ff : pix_rd_ff;

   always_comb begin
      pix_we = 1'b0;
      pix_wa = wr_idx_ff;
      pix_wd = (pix_rd & ~wr_mask_ff) | (wr_bits_ff & wr_mask_ff);
      if ((state_ff == ST_INIT) || (state_ff == ST_CLEAR)) begin
         pix_we = 1'b1;
         pix_wa = clr_cnt_ff;
         pix_wd = 8'h00;
      end else if (wr_pend_ff) begin
         pix_we = 1'b1;
      end
      byp_in = pix_we && (pix_wa == pix_ra);
   end

   always_comb begin
      gvalid_in = gvalid_ff;
      if (glyph_we) begin
         gvalid_in[glyph_idx] = 1'b1;
      end
   end

   // Next state and datapath control.
   always_comb begin
      state_in    = state_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      glyph_ok_in = glyph_ok_ff;
      rd_ok_in    = rd_ok_ff;
      lin_in      = lin_ff;
      pat_sr_in   = pat_sr_ff;
      op_cnt_in   = op_cnt_ff;
      clr_cnt_in  = clr_cnt_ff;
      res_in      = res_ff;
      wr_pend_in  = 1'b0;
      wr_idx_in   = op_idx[PIX_AW-1:0];
      wr_mask_in  = op_hi ? msk16[7:0] : msk16[15:8];
      wr_bits_in  = op_hi ? win16[7:0] : win16[15:8];
      pix_ra      = req_byte_address[PIX_AW-1:0];
      rsp_load    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               res_in      = 8'h00;
               glyph_ok_in = code_ok && gvalid_ff[glyph_idx];
               rd_ok_in    = BIX_W'(req_byte_address) < FRAME_BYTES_B;
               clr_cnt_in  = '0;
               case (req_kind)
                  KIND_TEXT: begin
                     x0_in    = 8'(col_m1 * TEXT_DX);
                     y0_in    = 8'(row_m1 * TEXT_DY);
                     state_in = ST_ORIGIN;
                  end
                  KIND_PIXEL: begin
                     x0_in    = req_pixel_x;
                     y0_in    = req_pixel_y;
                     state_in = ST_ORIGIN;
                  end
                  KIND_READ:  state_in = ST_READ;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_ORIGIN: begin
            // Unloaded and unknown glyphs draw blank.
            pat_sr_in = glyph_ok_ff ? {glyph_rd_ff, {(PAT_EXT_W - PAT_BITS){1'b0}}} : '0;
            lin_in    = LIN_W'(32'(y0_ff) * SCREEN_WIDTH) + LIN_W'(x0_ff);
            op_cnt_in = '0;
            state_in  = ST_BLIT;
         end
         ST_BLIT: begin
            // Even operations touch the first byte of a glyph row, odd ones
            // the byte after it.
            pix_ra     = op_idx[PIX_AW-1:0];
            wr_pend_in = op_idx < FRAME_BYTES_B;
            op_cnt_in  = op_cnt_ff + 1'b1;
            if (op_hi) begin
               lin_in    = lin_ff + ROW_STEP;
               pat_sr_in = pat_sr_ff << GLYPH_W;
            end
            if (op_cnt_ff == OP_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_READ: begin
            res_in   = rd_ok_ff ? pix_rd : 8'h00;
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase

      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gvalid_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         wr_pend_ff    <= 1'b0;
         byp_ff        <= 1'b0;
         clr_cnt_ff    <= '0;
      end else begin
         gvalid_ff     <= gvalid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         wr_pend_ff    <= wr_pend_in;
         byp_ff        <= byp_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      glyph_ok_ff <= glyph_ok_in;
      rd_ok_ff    <= rd_ok_in;
      lin_ff      <= lin_in;
      pat_sr_ff   <= pat_sr_in;
      op_cnt_ff   <= op_cnt_in;
      res_ff      <= res_in;
      wr_idx_ff   <= wr_idx_in;
      wr_mask_ff  <= wr_mask_in;
      wr_bits_ff  <= wr_bits_in;
      byp_data_ff <= pix_wd;
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // Glyph store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem_ff[glyph_idx] <= req_glyph_bits;
      end
      glyph_rd_ff <= glyph_mem_ff[glyph_idx];
   end

   // Frame store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem_ff[pix_wa] <= pix_wd;
      end
      pix_rd_ff <= pix_mem_ff[pix_ra];
   end

endmodule

>>> hw/rtl/gbb_checker.sv
// ---------------------------------------------------------------------------
// gbb_checker
// Port-level checks on the glyph blitter, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glyph_bitblit_1bpp_macros.svh"

module gbb_checker
   import gbb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [KIND_W-1:0]      req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [KIND_W-1:0] last_kind_ff;
   logic              last_is_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_kind_ff <= KIND_LOAD;
      end else if (req_tvalid && req_tready) begin
         last_kind_ff <= req_tuser;
      end
   end

   assign last_is_read = (last_kind_ff == KIND_READ);

   // The frame sweep after reset keeps the block closed and silent.
   `GBB_ASSERT_RST(a_reset_quiet, !req_tready && !rsp_tvalid, "busy state missing after reset")

   // Only one request is in work at a time.
   `GBB_ASSERT_NXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "second request taken while busy")

   `GBB_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // Only a byte read returns a non-zero response.
   `GBB_ASSERT_IMP(a_zero_unless_read, $rose(rsp_tvalid) && !last_is_read, rsp_tdata == '0, "non-read request returned data")

endmodule

bind glyph_bitblit_1bpp gbb_checker u_gbb_checker (.*);
